// ----- hdl/encoder_velocity_estimator_unit_assert.svh -----
// Assertion macros for the velocity estimator checker.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef ENCODER_VELOCITY_ESTIMATOR_UNIT_ASSERT_SVH
`define ENCODER_VELOCITY_ESTIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define EVU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EVU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/evu_pkg.sv -----
`timescale 1ns / 1ps
package evu_pkg;

  localparam int HISTORY_DEPTH_DEF = 5;

  localparam int POS_W      = 32;
  localparam int TIME_W     = 32;
  localparam int ANGLE_W    = 40;
  localparam int VEL_W      = 32;
  localparam int SCALE_W    = 19;
  localparam int DBAND_W    = 20;
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // |count delta| * 1000 fits in 42 bits; times the scale in 61 bits
  localparam int MAG_W  = 42;
  localparam int PROD_W = MAG_W + SCALE_W;
  localparam int QUOT_W = 32;

  localparam logic [SCALE_W-1:0] SCALE_RST = 19'd150;
  localparam logic [DBAND_W-1:0] DBAND_RST = 20'd200;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd2;

  localparam logic [VEL_W-1:0] VEL_POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0] VEL_NEG_LIMIT = 32'h8000_0000;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_SCALE = 2'd0,
    REG_DEADBAND    = 2'd1,
    REG_EMA_SHIFT   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// ----- hdl/evu_if.sv -----
`timescale 1ns / 1ps
interface evu_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic signed [evu_pkg::POS_W-1:0]  position;
  logic        [evu_pkg::TIME_W-1:0] time_ms;

  modport source (output valid, opcode, position, time_ms, input ready);
  modport sink   (input valid, opcode, position, time_ms, output ready);
endinterface

interface evu_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [evu_pkg::ANGLE_W-1:0] angle;
  logic signed [evu_pkg::VEL_W-1:0]   velocity;
  logic                               saturated;

  modport source (output valid, angle, velocity, saturated, input ready);
  modport sink   (input valid, angle, velocity, saturated, output ready);
endinterface

interface evu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [evu_pkg::CFG_IDX_W-1:0]     index;
  logic [evu_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/evu_mul.sv -----
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: one scale bit per cycle, LSB first.
// Runs two products at once: signed position * scale (angle) and
// unsigned |delta|*1000 * scale (velocity numerator).
module evu_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic        [evu_pkg::SCALE_W-1:0]  scale,
  input  logic signed [evu_pkg::POS_W-1:0]    pos,
  input  logic        [evu_pkg::MAG_W-1:0]    mag,
  output logic                                done,
  output logic signed [evu_pkg::ANGLE_W-1:0]  angle,
  output logic        [evu_pkg::PROD_W-1:0]   prod
);

  localparam int SCALE_W = evu_pkg::SCALE_W;
  localparam int POS_W   = evu_pkg::POS_W;
  localparam int MAG_W   = evu_pkg::MAG_W;
  localparam int CNT_W   = $clog2(SCALE_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SCALE_W - 1);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SCALE_W-1:0]      mult_r, mult_nxt;
  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic [MAG_W:0]          mhi_r, mhi_nxt;
  logic [SCALE_W-1:0]      mlo_r, mlo_nxt;
  logic signed [POS_W:0]   ahi_r, ahi_nxt;
  logic [SCALE_W-1:0]      alo_r, alo_nxt;
  logic [MAG_W:0]          msum;
  logic signed [POS_W:0]   asum;

  always_comb begin
    msum = mhi_r + (mult_r[0] ? {1'b0, mag_r} : '0);
    asum = ahi_r + (mult_r[0] ? {pos_r[POS_W-1], pos_r} : '0);

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mult_nxt = mult_r;
    pos_nxt  = pos_r;
    mag_nxt  = mag_r;
    mhi_nxt  = mhi_r;
    mlo_nxt  = mlo_r;
    ahi_nxt  = ahi_r;
    alo_nxt  = alo_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mult_nxt = scale;
      pos_nxt  = pos;
      mag_nxt  = mag;
      mhi_nxt  = '0;
      mlo_nxt  = '0;
      ahi_nxt  = '0;
      alo_nxt  = '0;
    end else if (busy_r) begin
      // add under the current multiplier bit, then shift one bit into the low half
      mult_nxt = mult_r >> 1;
      mhi_nxt  = msum >> 1;
      mlo_nxt  = {msum[0], mlo_r[SCALE_W-1:1]};
      ahi_nxt  = asum >>> 1;
      alo_nxt  = {asum[0], alo_r[SCALE_W-1:1]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mult_r <= mult_nxt;
    pos_r  <= pos_nxt;
    mag_r  <= mag_nxt;
    mhi_r  <= mhi_nxt;
    mlo_r  <= mlo_nxt;
    ahi_r  <= ahi_nxt;
    alo_r  <= alo_nxt;
  end

  assign done  = done_r;
  assign angle = {ahi_r[evu_pkg::ANGLE_W-SCALE_W-1:0], alo_r};
  assign prod  = {mhi_r[MAG_W-1:0], mlo_r};

endmodule

// ----- hdl/evu_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
// A quotient of 2^32 or more is flagged as overflow right at start.
module evu_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [evu_pkg::PROD_W-1:0]         dividend,
  input  logic [evu_pkg::QUOT_W-1:0]         divisor,
  output evu_pkg::div_stat_t                 stat,
  output logic [evu_pkg::QUOT_W-1:0]         quot
);

  localparam int QUOT_W = evu_pkg::QUOT_W;
  localparam int PROD_W = evu_pkg::PROD_W;
  localparam int CNT_W  = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QUOT_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [QUOT_W-1:0] rem_r, rem_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic [QUOT_W-1:0] dvs_r, dvs_nxt;
  logic [QUOT_W-1:0] hi;
  logic [QUOT_W+1:0] trial;

  always_comb begin
    hi    = QUOT_W'(dividend[PROD_W-1:QUOT_W]);
    trial = {1'b0, rem_r, q_r[QUOT_W-1]} - {2'b00, dvs_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;

    if (start) begin
      dvs_nxt = divisor;
      rem_nxt = hi;
      q_nxt   = dividend[QUOT_W-1:0];
      cnt_nxt = '0;
      ovf_nxt = (hi >= divisor);
      if (hi >= divisor) begin
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // dividend bits leave the top of q_r as quotient bits enter the bottom
      if (!trial[QUOT_W+1]) begin
        rem_nxt = trial[QUOT_W-1:0];
      end else begin
        rem_nxt = {rem_r[QUOT_W-2:0], q_r[QUOT_W-1]};
      end
      q_nxt   = {q_r[QUOT_W-2:0], ~trial[QUOT_W+1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign quot      = q_r;

endmodule

// ----- hdl/encoder_velocity_estimator_unit.sv -----
`timescale 1ns / 1ps
// Encoder velocity estimator. Each input word is a signed encoder count with a
// millisecond timestamp (or a reset opcode that refills the history and clears
// the filter); each produces exactly one result word with the angle in
// millidegrees, the filtered velocity in millidegrees per second and a flag for
// a clipped raw velocity. Items are handled one at a time: a word that makes
// no velocity update (reset opcode, first sample, zero elapsed time) goes
// through the multiplier only, one that updates also through the radix-2
// divider, stopped at start if the quotient overflows 32 bits. The bit-serial
// multiplier does one scale bit per cycle over 19 bits, the divider one quotient
// bit per cycle over 32 bits. The result register lets the next word be
// accepted while the previous result waits. Configuration words are taken at
// any time, cfg ready is always high, and must only be written while idle.
module encoder_velocity_estimator_unit #(
  parameter int HISTORY_DEPTH = evu_pkg::HISTORY_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  evu_in_if.sink    in_ch,
  evu_out_if.source out_ch,
  evu_cfg_if.sink   cfg_ch
);

  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int POS_W   = evu_pkg::POS_W;
  localparam int TIME_W  = evu_pkg::TIME_W;
  localparam int VEL_W   = evu_pkg::VEL_W;
  localparam int MAG_W   = evu_pkg::MAG_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MUL, S_DIV, S_DIFF, S_STEP, S_SNAP, S_HOLD
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [evu_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic [evu_pkg::DBAND_W-1:0] dband_r, dband_nxt;
  logic [evu_pkg::SHIFT_W-1:0] shift_r, shift_nxt;

  // history and filter state
  logic [POS_W-1:0]  pos_ring_r  [HISTORY_DEPTH];
  logic [POS_W-1:0]  pos_ring_nxt [HISTORY_DEPTH];
  logic [TIME_W-1:0] time_ring_r [HISTORY_DEPTH];
  logic [TIME_W-1:0] time_ring_nxt [HISTORY_DEPTH];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [VEL_W-1:0]  filt_r, filt_nxt;

  // current item
  logic                    op_r, op_nxt;
  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic [TIME_W-1:0]       time_r, time_nxt;
  logic                    neg_r, neg_nxt;
  logic                    dz_r, dz_nxt;
  logic                    upd_r, upd_nxt;
  logic [TIME_W-1:0]       dt_r, dt_nxt;
  logic [VEL_W+1:0]        diff_r, diff_nxt;
  logic                    sat_r, sat_nxt;
  logic [VEL_W-1:0]        fsum_r, fsum_nxt;
  logic [VEL_W-1:0]        pvel_r, pvel_nxt;
  logic                    psat_r, psat_nxt;

  // result register
  logic                               out_valid_r, out_valid_nxt;
  logic signed [evu_pkg::ANGLE_W-1:0] out_angle_r, out_angle_nxt;
  logic [VEL_W-1:0]                   out_vel_r, out_vel_nxt;
  logic                               out_sat_r, out_sat_nxt;

  // datapath helpers
  logic [FILL_W-1:0]  fill_inc;
  logic [SLOT_W-1:0]  slot_inc;
  logic [SLOT_W-1:0]  oldest;
  logic [POS_W-1:0]   dcount;
  logic [TIME_W-1:0]  dt;
  logic [POS_W-1:0]   absd;
  logic [MAG_W-1:0]   absd_ext;
  logic [MAG_W-1:0]   mag1000;
  logic               big;
  logic [VEL_W-1:0]   qs;
  logic [VEL_W:0]     raw;
  logic               dneg;
  logic [VEL_W+1:0]   dabs_full;
  logic [VEL_W:0]     dabs;
  logic [VEL_W:0]     dsh;
  logic [VEL_W:0]     stepv;
  logic [VEL_W-1:0]   fabs;
  logic               snap;
  logic               in_acc;
  logic               out_free;

  // unit hookups
  logic                               mul_start;
  logic                               mul_done;
  logic signed [evu_pkg::ANGLE_W-1:0] mul_angle;
  logic [evu_pkg::PROD_W-1:0]         mul_prod;
  logic                               div_start;
  evu_pkg::div_stat_t                 div_stat;
  logic [evu_pkg::QUOT_W-1:0]         div_quot;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign mul_start = (state_r == S_PREP);
  assign div_start = (state_r == S_MUL) && mul_done && upd_r;

  evu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .scale (scale_r),
    .pos   (pos_r),
    .mag   (mag1000),
    .done  (mul_done),
    .angle (mul_angle),
    .prod  (mul_prod)
  );

  evu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_prod),
    .divisor  (dt_r),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  // configuration writes
  always_comb begin
    scale_nxt = scale_r;
    dband_nxt = dband_r;
    shift_nxt = shift_r;
    if (cfg_ch.valid) begin
      unique case (evu_pkg::cfg_reg_t'(cfg_ch.index))
        evu_pkg::REG_ANGLE_SCALE: scale_nxt = cfg_ch.data[evu_pkg::SCALE_W-1:0];
        evu_pkg::REG_DEADBAND:    dband_nxt = cfg_ch.data[evu_pkg::DBAND_W-1:0];
        evu_pkg::REG_EMA_SHIFT:   shift_nxt = cfg_ch.data[evu_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // history indexing and the velocity numerator
  always_comb begin
    fill_inc = (fill_r < FILL_W'(HISTORY_DEPTH)) ? fill_r + 1'b1 : fill_r;
    slot_inc = (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    // oldest is slot 0 until the ring fills, then the slot overwritten next
    oldest   = (fill_inc < FILL_W'(HISTORY_DEPTH)) ? '0 : slot_inc;
    dcount   = pos_r - pos_ring_r[oldest];
    dt       = time_r - time_ring_r[oldest];
    absd     = dcount[POS_W-1] ? -dcount : dcount;
    absd_ext = MAG_W'(absd);
    // x * 1000 = x * 1024 - x * 16 - x * 8
    mag1000  = (absd_ext << 10) - (absd_ext << 4) - (absd_ext << 3);
  end

  // clip, filter step and deadband
  always_comb begin
    big = div_stat.ovf ||
          (neg_r ? (div_quot[VEL_W-1] && (|div_quot[VEL_W-2:0])) : div_quot[VEL_W-1]);
    if (big) begin
      qs = neg_r ? evu_pkg::VEL_NEG_LIMIT : evu_pkg::VEL_POS_LIMIT;
    end else begin
      qs = div_quot;
    end
    raw       = neg_r ? -{1'b0, qs} : {1'b0, qs};
    dneg      = diff_r[VEL_W+1];
    dabs_full = dneg ? -diff_r : diff_r;
    dabs      = dabs_full[VEL_W:0];
    dsh       = dabs >> shift_r;
    stepv     = dneg ? -dsh : dsh;
    fabs      = fsum_r[VEL_W-1] ? -fsum_r : fsum_r;
    snap      = dz_r && (fabs < VEL_W'(dband_r));
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    filt_nxt      = filt_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    time_nxt      = time_r;
    neg_nxt       = neg_r;
    dz_nxt        = dz_r;
    upd_nxt       = upd_r;
    dt_nxt        = dt_r;
    diff_nxt      = diff_r;
    sat_nxt       = sat_r;
    fsum_nxt      = fsum_r;
    pvel_nxt      = pvel_r;
    psat_nxt      = psat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_angle_nxt = out_angle_r;
    out_vel_nxt   = out_vel_r;
    out_sat_nxt   = out_sat_r;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      pos_ring_nxt[i]  = pos_ring_r[i];
      time_ring_nxt[i] = time_ring_r[i];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_ch.opcode;
          pos_nxt   = in_ch.position;
          time_nxt  = in_ch.time_ms;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        neg_nxt = dcount[POS_W-1];
        dz_nxt  = (dcount == '0);
        dt_nxt  = dt;
        upd_nxt = (op_r == evu_pkg::OP_SAMPLE) && (fill_inc > FILL_W'(1)) && (dt != '0);
        if (op_r == evu_pkg::OP_RESET) begin
          for (int i = 0; i < HISTORY_DEPTH; i++) begin
            pos_ring_nxt[i]  = pos_r;
            time_ring_nxt[i] = time_r;
          end
          slot_nxt = '0;
          fill_nxt = '0;
        end else begin
          for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (slot_r == SLOT_W'(i)) begin
              pos_ring_nxt[i]  = pos_r;
              time_ring_nxt[i] = time_r;
            end
          end
          slot_nxt = slot_inc;
          fill_nxt = fill_inc;
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = upd_r ? S_DIV : S_DIFF;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        diff_nxt  = {raw[VEL_W], raw} - {{2{filt_r[VEL_W-1]}}, filt_r};
        sat_nxt   = big;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        fsum_nxt  = filt_r + stepv[VEL_W-1:0];
        state_nxt = S_SNAP;
      end
      S_SNAP: begin
        if (op_r == evu_pkg::OP_RESET) begin
          filt_nxt = '0;
        end else if (upd_r) begin
          filt_nxt = snap ? '0 : fsum_r;
        end
        pvel_nxt  = (op_r == evu_pkg::OP_RESET) ? '0 :
                    (upd_r ? (snap ? '0 : fsum_r) : filt_r);
        psat_nxt  = upd_r && sat_r;
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        // hand off once the result register is empty or being drained
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_angle_nxt = mul_angle;
          out_vel_nxt   = pvel_r;
          out_sat_nxt   = psat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_angle_r <= out_angle_nxt;
      out_vel_r   <= out_vel_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= evu_pkg::SCALE_RST;
      dband_r <= evu_pkg::DBAND_RST;
      shift_r <= evu_pkg::SHIFT_RST;
      slot_r  <= '0;
      fill_r  <= '0;
      filt_r  <= '0;
    end else begin
      scale_r <= scale_nxt;
      dband_r <= dband_nxt;
      shift_r <= shift_nxt;
      slot_r  <= slot_nxt;
      fill_r  <= fill_nxt;
      filt_r  <= filt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      pos_ring_r[i]  <= pos_ring_nxt[i];
      time_ring_r[i] <= time_ring_nxt[i];
    end
    op_r   <= op_nxt;
    pos_r  <= pos_nxt;
    time_r <= time_nxt;
    neg_r  <= neg_nxt;
    dz_r   <= dz_nxt;
    upd_r  <= upd_nxt;
    dt_r   <= dt_nxt;
    diff_r <= diff_nxt;
    sat_r  <= sat_nxt;
    fsum_r <= fsum_nxt;
    pvel_r <= pvel_nxt;
    psat_r <= psat_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.angle     = out_angle_r;
  assign out_ch.velocity  = out_vel_r;
  assign out_ch.saturated = out_sat_r;

endmodule

// ----- hdl/evu_checker.sv -----
`timescale 1ns / 1ps
`include "encoder_velocity_estimator_unit_assert.svh"
module evu_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [evu_pkg::ANGLE_W-1:0] out_angle,
  input logic signed [evu_pkg::VEL_W-1:0]   out_velocity,
  input logic                               out_saturated
);

  // a stalled result word holds
`EVU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_angle) && $stable(out_velocity) && $stable(out_saturated), "result word changed while stalled")

  // an accepted word keeps input ready low while it passes the PREP and MUL states
`EVU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready ##1 !in_ready, "input ready too soon after accept")

  // a new result word appears only as the block goes idle
`EVU_ASSERT_NOW(a_word_when_idle, $rose(out_valid), in_ready, "result word appeared while busy")

endmodule

bind encoder_velocity_estimator_unit evu_checker u_evu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_angle     (out_ch.angle),
  .out_velocity  (out_ch.velocity),
  .out_saturated (out_ch.saturated)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import evu_pkg::*;

  localparam int HIST          = HISTORY_DEPTH_DEF;
  localparam int RUN_WORDS     = 200;
  localparam int NUM_PHASES    = 8;
  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [VEL_W-1:0]   velocity;
    logic                      saturated;
  } reading_t;

  // Tracks ring, filter and registers alongside the block; predicts one reading per word.
  class velocity_checker;
    bit [POS_W-1:0]   pos_hist[HIST];
    bit [TIME_W-1:0]  time_hist[HIST];
    int unsigned      wr_slot;
    int unsigned      fill;
    int               filt;
    bit [SCALE_W-1:0] scale;
    bit [DBAND_W-1:0] dband;
    bit [SHIFT_W-1:0] shift;
    reading_t         pending_readings[$];
    int               errors;
    int               n_words, n_resets, n_checked, n_clipped, n_snapped;

    function new();
      foreach (pos_hist[i]) begin
        pos_hist[i]  = '0;
        time_hist[i] = '0;
      end
      wr_slot = 0;
      fill    = 0;
      filt    = 0;
      scale   = SCALE_RST;
      dband   = DBAND_RST;
      shift   = SHIFT_RST;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ANGLE_SCALE: scale = value[SCALE_W-1:0];
        REG_DEADBAND:    dband = value[DBAND_W-1:0];
        REG_EMA_SHIFT:   shift = value[SHIFT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(logic op, logic [POS_W-1:0] pos, logic [TIME_W-1:0] now);
      reading_t          r;
      bit [31:0]         dcount, dt;
      longint            d, raw, diff, stepv, f, p64, prod;
      longint unsigned   mag, q, dmag, fm, scale_l, dband_l;
      int unsigned       oldest;
      bit                clip;
      clip    = 1'b0;
      scale_l = 64'(scale);
      dband_l = 64'(dband);
      n_words++;
      if (op == OP_RESET) begin
        foreach (pos_hist[i]) begin
          pos_hist[i]  = pos;
          time_hist[i] = now;
        end
        wr_slot = 0;
        fill    = 0;
        filt    = 0;
        n_resets++;
      end else begin
        pos_hist[wr_slot]  = pos;
        time_hist[wr_slot] = now;
        wr_slot = (wr_slot + 1) % HIST;
        if (fill < HIST) fill++;
        if (fill > 1) begin
          oldest = (fill < HIST) ? 0 : wr_slot;
          dcount = pos - pos_hist[oldest];
          dt     = now - time_hist[oldest];
          if (dt != 0) begin
            d   = longint'($signed(dcount));
            mag = (d < 0) ? -d : d;
            mag = mag * scale_l * 64'd1000;
            q   = mag / {32'd0, dt};
            if (d >= 0 && q > 64'd2147483647) begin
              q    = 64'd2147483647;
              clip = 1'b1;
            end else if (d < 0 && q > 64'd2147483648) begin
              q    = 64'd2147483648;
              clip = 1'b1;
            end
            raw   = (d < 0) ? -longint'(q) : longint'(q);
            diff  = raw - longint'(filt);
            dmag  = (diff < 0) ? -diff : diff;
            dmag  = dmag >> shift;
            stepv = (diff < 0) ? -longint'(dmag) : longint'(dmag);
            filt  = int'(longint'(filt) + stepv);
            // snap to zero only when the count has not moved over the window
            if (dcount == 0) begin
              f  = longint'(filt);
              fm = (f < 0) ? -f : f;
              if (fm < dband_l) begin
                if (filt != 0) n_snapped++;
                filt = 0;
              end
            end
          end
        end
      end
      p64  = longint'($signed(pos));
      prod = p64 * longint'(scale_l);
      r.angle     = prod[ANGLE_W-1:0];
      r.velocity  = filt;
      r.saturated = clip;
      if (clip) n_clipped++;
      pending_readings.push_back(r);
    endfunction

    function void check_result(logic signed [ANGLE_W-1:0] angle,
                               logic signed [VEL_W-1:0] velocity, logic saturated);
      reading_t e;
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected: angle %0d velocity %0d sat %0b",
                 $time, angle, velocity, saturated);
        return;
      end
      e = pending_readings.pop_front();
      n_checked++;
      if (angle !== e.angle) begin
        errors++;
        if (errors <= 40)
          $display("%0t: angle mismatch: expected %0d, actual %0d", $time, e.angle, angle);
      end
      if (velocity !== e.velocity) begin
        errors++;
        if (errors <= 40)
          $display("%0t: velocity mismatch: expected %0d, actual %0d",
                   $time, e.velocity, velocity);
      end
      if (saturated !== e.saturated) begin
        errors++;
        if (errors <= 40)
          $display("%0t: saturated mismatch: expected %0b, actual %0b",
                   $time, e.saturated, saturated);
      end
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  evu_in_if  in_ch();
  evu_out_if out_ch();
  evu_cfg_if cfg_ch();

  encoder_velocity_estimator_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  velocity_checker chk = new();

  bit          in_steady;
  bit          out_steady;
  bit [31:0]   cur_pos;
  bit [31:0]   cur_time;
  int unsigned hold_left;
  bit          freeze_time;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(input logic op, input logic [POS_W-1:0] pos,
                           input logic [TIME_W-1:0] t);
    int gap;
    if ($urandom_range(0, 31) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.position <= pos;
    in_ch.time_ms  <= t;
    do @(posedge clk); while (!in_ch.ready);
    chk.note_word(op, pos, t);
  endtask

  // Mostly a plausible trajectory; some history resets, some fully random words.
  task automatic send_random();
    int unsigned r, k;
    bit [31:0]   dp, dtm;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      cur_pos  = $urandom;
      cur_time = $urandom;
      send_word(OP_RESET, cur_pos, cur_time);
    end else if (r < 8) begin
      send_word(OP_SAMPLE, $urandom, $urandom);
    end else begin
      dtm = 32'd0;
      if (hold_left > 0) begin
        dp = 32'd0;
        hold_left--;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 10) begin
          hold_left   = $urandom_range(3, 10);
          freeze_time = ($urandom_range(0, 2) == 0);
          dp          = 32'd0;
        end else if (k < 25) dp = 32'd0;
        else if (k < 65) dp = $urandom_range(0, 400) - 200;
        else if (k < 90) dp = $urandom_range(0, 140000) - 70000;
        else dp = $urandom;
      end
      if (!(hold_left > 0 && freeze_time)) begin
        k = $urandom_range(0, 99);
        if (k < 8) dtm = 32'd0;
        else if (k < 80) dtm = $urandom_range(1, 20);
        else if (k < 95) dtm = $urandom_range(21, 5000);
        else dtm = $urandom;
      end
      cur_pos  = cur_pos + dp;
      cur_time = cur_time + dtm;
      send_word(OP_SAMPLE, cur_pos, cur_time);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    chk.set_reg(idx, value);
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] scale_word,
                             input logic [CFG_DATA_W-1:0] dband_word,
                             input logic [CFG_DATA_W-1:0] shift_word);
    write_reg(REG_ANGLE_SCALE, scale_word);
    write_reg(REG_DEADBAND, dband_word);
    write_reg(REG_EMA_SHIFT, shift_word);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drain every outstanding reading, then let the datapath settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int ph;
    logic [CFG_DATA_W-1:0] sc, db, sh;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_SAMPLE;
    in_ch.position <= '0;
    in_ch.time_ms  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_ANGLE_SCALE;
    cfg_ch.data    <= '0;
    out_ch.ready   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: first sample, zero elapsed, deadband snap, clipping
    send_word(OP_SAMPLE, 32'd0, 32'd0);
    send_word(OP_SAMPLE, 32'd0, 32'd0);
    send_word(OP_SAMPLE, 32'd1, 32'd1000);
    send_word(OP_SAMPLE, 32'd0, 32'd2000);
    send_word(OP_SAMPLE, 32'h7FFF_FFFF, 32'd2001);
    // count and timestamp wrap, full-scale negative delta
    send_word(OP_RESET, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
    send_word(OP_SAMPLE, 32'h8000_0000, 32'hFFFF_FFF0);
    send_word(OP_SAMPLE, 32'h8000_0000, 32'd5);
    send_word(OP_SAMPLE, 32'h7FFF_FFFF, 32'd6);
    send_word(OP_SAMPLE, 32'd0, 32'd7);
    send_word(OP_RESET, 32'h8000_0000, 32'd0);
    send_word(OP_SAMPLE, 32'h8000_0000, 32'd0);
    send_word(OP_SAMPLE, 32'h8000_0001, 32'd0);
    send_word(OP_SAMPLE, 32'h8000_0064, 32'd1);
    send_word(OP_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_SAMPLE, 32'hAAAA_AAAA, 32'h5555_5555);
    send_word(OP_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA);
    send_word(OP_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAB);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin sc = 20'd150;     db = 20'd200;     sh = 20'd2;  end
        1: begin sc = 20'd360000;  db = 20'd1000000; sh = 20'd15; end
        2: begin sc = 20'd1;       db = 20'd0;       sh = 20'd0;  end
        3: begin sc = 20'd0;       db = 20'd200;     sh = 20'd4;  end
        4: begin sc = 20'hFFFFF;   db = 20'hFFFFF;   sh = 20'd1;  end
        default: begin
          sc = CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
          db = CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
          sh = CFG_DATA_W'($urandom_range(0, 15));
        end
      endcase
      load_config(sc, db, sh);
      repeat (RUN_WORDS) send_random();
      drain();
    end

    $display("Sent %0d words (%0d history resets) over %0d register settings.",
             chk.n_words, chk.n_resets, NUM_PHASES + 1);
    $display("Checked %0d readings: %0d with clipped velocity, %0d snapped to zero.",
             chk.n_checked, chk.n_clipped, chk.n_snapped);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("** encoder_velocity_estimator_unit: PASSED **");
    end else begin
      $display("** encoder_velocity_estimator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      chk.check_result(out_ch.angle, out_ch.velocity, out_ch.saturated);
    end
  end

  // Stop a hung run: count cycles in which no channel moves a word.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d readings outstanding",
               $time, QUIET_LIMIT, chk.pending());
      $display("** encoder_velocity_estimator_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
